/* hdl/compacted_string_list_table_assert.svh */
// Assertion macros for the compacted string list table.
// Used by the top level; expects clk and rst_n in scope.
`ifndef COMPACTED_STRING_LIST_TABLE_ASSERT_SVH
`define COMPACTED_STRING_LIST_TABLE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define CSLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that one condition implies another on the following edge.
`define CSLT_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* hdl/cslt_pkg.sv */
// Shared types, request and status codes for the compacted string list table.
// Used by cslt_entry_ram and compacted_string_list_table; no dependencies.
package cslt_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int ITEM_CHARS = 19;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_CLEAR  = 3'd2;
    localparam logic [2:0] REQ_COUNT  = 3'd3;
    localparam logic [2:0] REQ_DUMP   = 3'd4;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_MISS = 2'd2;

    typedef struct packed {
        logic [23:0] hi;
        logic [63:0] mid;
        logic [63:0] lo;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    // Keep characters up to the first zero byte, clear the rest.
    function automatic entry_t normalize(input entry_t raw);
        logic [151:0] flat;
        logic [151:0] res;
        logic         keep;
        flat = {raw.hi, raw.mid, raw.lo};
        res  = '0;
        keep = 1'b1;
        for (int k = 0; k < 19; k++) begin
            keep = keep && (flat[8*k +: 8] != 8'd0) && (k < ITEM_CHARS);
            if (keep) begin
                res[8*k +: 8] = flat[8*k +: 8];
            end
        end
        return entry_t'(res);
    endfunction

endpackage

/* hdl/cslt_entry_ram.sv */
// Entry store of the list: one write port, one read port, registered read data.
// Depends on cslt_pkg for entry_t and mem_req_t.
module cslt_entry_ram
    import cslt_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mem_req,
    input  entry_t   wdata,
    output entry_t   rdata
);

    entry_t mem [LIST_DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= wdata;
        end
        rdata <= mem[mem_req.raddr];
    end

endmodule

/* hdl/compacted_string_list_table.sv */
// Compacted string list table: ordered gap-free list of short strings in one RAM.
// Insert, clear, count and empty remove: result from ST_RESP through the output register.
// Remove: search entries in ST_SEARCH, shift later entries down in ST_SHIFT, then ST_RESP.
// Dump of n entries: n results on consecutive cycles while out_ready allows, after the first RAM read.
// One request at a time; RAM read latency sets the pace of search, shift and dump.
// Reset (rst_n low, asynchronous) empties the list; RAM contents are not cleared.
module compacted_string_list_table
    import cslt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        req_type,
    input  logic [63:0]       item_bytes_lo,
    input  logic [63:0]       item_bytes_mid,
    input  logic [23:0]       item_bytes_hi,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [CNT_W-1:0]  entry_total,
    output logic [63:0]       out_bytes_lo,
    output logic [63:0]       out_bytes_mid,
    output logic [23:0]       out_bytes_hi,
    output logic              entry_valid,
    output logic              last_result
);

    `include "compacted_string_list_table_assert.svh"

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_SHIFT  = 5'b00100,
        ST_DUMP   = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       stat_reg, stat_next;
    entry_t           item_reg, item_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_stat_reg, out_stat_next;
    logic [CNT_W-1:0] out_total_reg, out_total_next;
    entry_t           out_entry_reg, out_entry_next;
    logic             out_ev_reg, out_ev_next;
    logic             out_last_reg, out_last_next;

    mem_req_t         mem_req;
    entry_t           mem_wdata;
    entry_t           mem_rdata;

    entry_t           in_item;
    logic             in_accept;
    logic             slot_free;
    logic             idx_last;
    logic             idx_has_two;
    logic             list_full;

    cslt_entry_ram u_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .wdata   (mem_wdata),
        .rdata   (mem_rdata)
    );

    assign in_item     = normalize(entry_t'({item_bytes_hi, item_bytes_mid, item_bytes_lo}));
    assign in_ready    = (state_reg == ST_IDLE);
    assign in_accept   = in_valid && in_ready;
    assign slot_free   = !out_valid_reg || out_ready;
    assign idx_last    = (CNT_W'(idx_reg) + CNT_W'(1)) >= count_reg;
    assign idx_has_two = (CNT_W'(idx_reg) + CNT_W'(2)) < count_reg;
    assign list_full   = (count_reg >= CNT_W'(LIST_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        stat_next      = stat_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_stat_next  = out_stat_reg;
        out_total_next = out_total_reg;
        out_entry_next = out_entry_reg;
        out_ev_next    = out_ev_reg;
        out_last_next  = out_last_reg;
        mem_req.we     = 1'b0;
        mem_req.waddr  = idx_reg;
        mem_req.raddr  = idx_reg;
        mem_wdata      = mem_rdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_req.raddr = '0;
                if (in_accept)
                begin
                    item_next  = in_item;
                    idx_next   = '0;
                    stat_next  = STAT_OK;
                    state_next = ST_RESP;
                    priority case (req_type)
                        REQ_INSERT:
                        begin
                            if (in_item.lo[7:0] != 8'd0)
                            begin
                                if (list_full)
                                begin
                                    stat_next = STAT_FULL;
                                end
                                else
                                begin
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = count_reg[IDX_W-1:0];
                                    mem_wdata     = in_item;
                                    count_next    = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (in_item.lo[7:0] == 8'd0)
                            begin
                                stat_next = list_full ? STAT_MISS : STAT_OK;
                            end
                            else if (count_reg == '0)
                            begin
                                stat_next = STAT_MISS;
                            end
                            else
                            begin
                                state_next = ST_SEARCH;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        REQ_DUMP:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (mem_rdata == item_reg)
                begin
                    if (idx_last)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        mem_req.raddr = idx_reg + IDX_W'(1);
                        state_next    = ST_SHIFT;
                    end
                end
                else if (idx_last)
                begin
                    stat_next  = STAT_MISS;
                    state_next = ST_RESP;
                end
                else
                begin
                    mem_req.raddr = idx_reg + IDX_W'(1);
                    idx_next      = idx_reg + IDX_W'(1);
                end
            end
            ST_SHIFT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                if (idx_has_two)
                begin
                    mem_req.raddr = idx_reg + IDX_W'(2);
                    idx_next      = idx_reg + IDX_W'(1);
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_RESP;
                end
            end
            ST_DUMP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = STAT_OK;
                    out_total_next = count_reg;
                    out_entry_next = mem_rdata;
                    out_ev_next    = 1'b1;
                    out_last_next  = idx_last;
                    if (idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_req.raddr = idx_reg + IDX_W'(1);
                        idx_next      = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_total_next = count_reg;
                    out_entry_next = '0;
                    out_ev_next    = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg      <= stat_next;
        item_reg      <= item_next;
        out_stat_reg  <= out_stat_next;
        out_total_reg <= out_total_next;
        out_entry_reg <= out_entry_next;
        out_ev_reg    <= out_ev_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_stat_reg;
    assign entry_total   = out_total_reg;
    assign out_bytes_lo  = out_entry_reg.lo;
    assign out_bytes_mid = out_entry_reg.mid;
    assign out_bytes_hi  = out_entry_reg.hi;
    assign entry_valid   = out_ev_reg;
    assign last_result   = out_last_reg;

    `CSLT_ASSERT(a_count_bound, count_reg <= CNT_W'(LIST_DEPTH), "entry count above depth")
    `CSLT_ASSERT(a_write_in_list, !mem_req.we || (CNT_W'(mem_req.waddr) < count_next),
        "write outside the list")
    `CSLT_ASSERT(a_entry_ok, !(out_valid_reg && out_ev_reg) || (out_stat_reg == STAT_OK),
        "entry result with error status")
    `CSLT_ASSERT_NEXT(a_busy_after_accept, in_accept, state_reg != ST_IDLE,
        "idle right after a request")

endmodule
